[sv/pfc_pkg.sv]
// Shared types, constants and helper functions for the Playfair digraph cipher block.
package pfc_pkg;

   localparam int SIDE  = 5;
   localparam int CELLS = SIDE * SIDE;

   localparam int LETTER_W  = 5;
   localparam int POS_W     = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam int SQ_LOW_W  = 40;
   localparam int SQ_MID_W  = 40;
   localparam int SQ_HIGH_W = 45;

   typedef logic [LETTER_W-1:0]              letter_type;
   typedef logic [POS_W-1:0]                 pos_type;
   typedef logic [CELLS-1:0]                 hit_type;
   typedef logic [CELLS-1:0][LETTER_W-1:0]   square_type;

   // Register index, taken from paddr[4:3].
   typedef enum logic [1:0] {
      REG_SQ_LOW  = 2'd0,
      REG_SQ_MID  = 2'd1,
      REG_SQ_HIGH = 2'd2,
      REG_MODE    = 2'd3
   } reg_index_type;

   typedef struct packed {
      hit_type hit_first;
      hit_type hit_second;
   } match_type;

   typedef struct packed {
      pos_type row_first;
      pos_type col_first;
      pos_type row_second;
      pos_type col_second;
      logic    found_first;
      logic    found_second;
   } loc_type;

   typedef struct packed {
      letter_type idx_first;
      letter_type idx_second;
      logic       not_found;
   } route_type;

   // Step one position along a row or column with wrap.
   function automatic pos_type next_pos(input pos_type pos, input logic decrypt);
      pos_type result;
      if (decrypt) begin
         result = (pos == '0) ? pos_type'(SIDE - 1) : pos - pos_type'(1);
      end else begin
         result = (pos == pos_type'(SIDE - 1)) ? '0 : pos + pos_type'(1);
      end
      return result;
   endfunction

   // Row-major cell number of a row and column.
   function automatic letter_type cell_index(input pos_type row, input pos_type col);
      return letter_type'(row) * letter_type'(SIDE) + letter_type'(col);
   endfunction

endpackage

[sv/pfc_req_if.sv]
// Input channel interface carrying one letter pair per beat.
interface pfc_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] first_letter;
   logic [4:0] second_letter;

   modport source (output valid, output first_letter, output second_letter, input ready);
   modport sink   (input valid, input first_letter, input second_letter, output ready);
endinterface

[sv/pfc_rsp_if.sv]
// Result channel interface carrying one transformed pair per beat.
interface pfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] out_first;
   logic [4:0] out_second;
   logic       not_found;

   modport source (output valid, output out_first, output out_second, output not_found,
                   input ready);
   modport sink   (input valid, input out_first, input out_second, input not_found,
                   output ready);
endinterface

[sv/pfc_match.sv]
// Stage one: compares both letters against every cell of the key square.
module pfc_match (
   input  logic                 clock,
   input  logic                 reset,
   pfc_req_if.sink              req_chan,
   input  pfc_pkg::square_type  cells,
   output logic                 down_valid,
   input  logic                 down_ready,
   output pfc_pkg::match_type   down_data
);
   import pfc_pkg::*;

   logic      valid_ff;
   match_type data_ff;
   match_type data_in;

   assign req_chan.ready = !valid_ff || down_ready;

   always_comb begin
      for (int n = 0; n < CELLS; n++) begin
         data_in.hit_first[n]  = (cells[n] == req_chan.first_letter);
         data_in.hit_second[n] = (cells[n] == req_chan.second_letter);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;
endmodule

[sv/pfc_locate.sv]
// Stage two: picks the first matching cell and turns it into a row and column.
module pfc_locate (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  pfc_pkg::match_type  up_data,
   output logic                down_valid,
   input  logic                down_ready,
   output pfc_pkg::loc_type    down_data
);
   import pfc_pkg::*;

   logic    valid_ff;
   loc_type data_ff;
   loc_type data_in;
   hit_type first_hit_a;
   hit_type first_hit_b;

   assign up_ready = !valid_ff || down_ready;

   // Isolating the lowest set bit gives the first match in row-major order.
   always_comb begin
      first_hit_a = up_data.hit_first  & (~up_data.hit_first  + hit_type'(1));
      first_hit_b = up_data.hit_second & (~up_data.hit_second + hit_type'(1));
      data_in = '0;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            if (first_hit_a[r*SIDE+c]) begin
               data_in.row_first = data_in.row_first | pos_type'(r);
               data_in.col_first = data_in.col_first | pos_type'(c);
            end
            if (first_hit_b[r*SIDE+c]) begin
               data_in.row_second = data_in.row_second | pos_type'(r);
               data_in.col_second = data_in.col_second | pos_type'(c);
            end
         end
      end
      data_in.found_first  = |up_data.hit_first;
      data_in.found_second = |up_data.hit_second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;
endmodule

[sv/pfc_route.sv]
// Stage three: applies the row, column or rectangle rule and forms target cell numbers.
module pfc_route (
   input  logic                clock,
   input  logic                reset,
   input  logic                decrypt,
   input  logic                up_valid,
   output logic                up_ready,
   input  pfc_pkg::loc_type    up_data,
   output logic                down_valid,
   input  logic                down_ready,
   output pfc_pkg::route_type  down_data
);
   import pfc_pkg::*;

   logic      valid_ff;
   route_type data_ff;
   route_type data_in;
   pos_type   row_a;
   pos_type   col_a;
   pos_type   row_b;
   pos_type   col_b;

   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      priority if (up_data.row_first == up_data.row_second) begin
         row_a = up_data.row_first;
         col_a = next_pos(up_data.col_first, decrypt);
         row_b = up_data.row_second;
         col_b = next_pos(up_data.col_second, decrypt);
      end else if (up_data.col_first == up_data.col_second) begin
         row_a = next_pos(up_data.row_first, decrypt);
         col_a = up_data.col_first;
         row_b = next_pos(up_data.row_second, decrypt);
         col_b = up_data.col_second;
      end else begin
         row_a = up_data.row_first;
         col_a = up_data.col_second;
         row_b = up_data.row_second;
         col_b = up_data.col_first;
      end
      data_in.idx_first  = cell_index(row_a, col_a);
      data_in.idx_second = cell_index(row_b, col_b);
      data_in.not_found  = !(up_data.found_first && up_data.found_second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;
endmodule

[sv/pfc_select.sv]
// Stage four: reads the target cells and holds the result beat in the output register.
module pfc_select (
   input  logic                clock,
   input  logic                reset,
   input  pfc_pkg::square_type cells,
   input  logic                up_valid,
   output logic                up_ready,
   input  pfc_pkg::route_type  up_data,
   pfc_rsp_if.source           rsp_chan
);
   import pfc_pkg::*;

   logic       valid_ff;
   letter_type first_ff;
   letter_type second_ff;
   logic       not_found_ff;
   letter_type first_in;
   letter_type second_in;

   assign up_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      if (up_data.not_found) begin
         first_in  = '0;
         second_in = '0;
      end else begin
         first_in  = cells[up_data.idx_first];
         second_in = cells[up_data.idx_second];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         first_ff     <= first_in;
         second_ff    <= second_in;
         not_found_ff <= up_data.not_found;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.out_first  = first_ff;
   assign rsp_chan.out_second = second_ff;
   assign rsp_chan.not_found  = not_found_ff;
endmodule

[sv/playfair_digraph_cipher_top.sv]
// Top level of the Playfair digraph cipher: register file and four-stage pipeline.
//
//   Channel   Direction  Handshake          Beat contents
//   req_chan  in         valid / ready      first_letter, second_letter
//   rsp_chan  out        valid / ready      out_first, out_second, not_found
//   csr (APB) in         psel/penable/pready four key-square and mode registers
//
// A pair accepted on req_chan passes the match, locate, route and select registers in
// order and then waits on rsp_chan; a new pair can be accepted at every edge while
// rsp_chan is not stalled. The four stages are cell compare, first-match locate, rule
// routing and cell read, and the stage count sets the latency.
// Reset clears the valid bits of all stages and every configuration register.
// A stall on rsp_chan backs up stage by stage, and empty stages fill first.
module playfair_digraph_cipher_top (
   input  logic                               clock,
   input  logic                               reset,
   pfc_req_if.sink                            req_chan,
   pfc_rsp_if.source                          rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pfc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pfc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import pfc_pkg::*;

   // Configuration registers. Registers sit eight bytes apart, so bits 4:3 of
   // the address select one and the low bits are ignored.
   logic [SQ_LOW_W-1:0]  sq_low_ff;
   logic [SQ_MID_W-1:0]  sq_mid_ff;
   logic [SQ_HIGH_W-1:0] sq_high_ff;
   logic                 mode_ff;
   logic [SQ_LOW_W-1:0]  sq_low_in;
   logic [SQ_MID_W-1:0]  sq_mid_in;
   logic [SQ_HIGH_W-1:0] sq_high_in;
   logic                 mode_in;
   logic                 csr_write;
   reg_index_type        csr_index;
   square_type           cells;

   // Pipeline links between the stages.
   logic      s1_valid;
   logic      s1_ready;
   match_type s1_data;
   logic      s2_valid;
   logic      s2_ready;
   loc_type   s2_data;
   logic      s3_valid;
   logic      s3_ready;
   route_type s3_data;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[4:3]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      sq_low_in  = sq_low_ff;
      sq_mid_in  = sq_mid_ff;
      sq_high_in = sq_high_ff;
      mode_in    = mode_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SQ_LOW:  sq_low_in  = pwdata[SQ_LOW_W-1:0];
            REG_SQ_MID:  sq_mid_in  = pwdata[SQ_MID_W-1:0];
            REG_SQ_HIGH: sq_high_in = pwdata[SQ_HIGH_W-1:0];
            REG_MODE:    mode_in    = pwdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_low_ff  <= '0;
         sq_mid_ff  <= '0;
         sq_high_ff <= '0;
         mode_ff    <= 1'b0;
      end else begin
         sq_low_ff  <= sq_low_in;
         sq_mid_ff  <= sq_mid_in;
         sq_high_ff <= sq_high_in;
         mode_ff    <= mode_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SQ_LOW:  prdata = CSR_DATA_W'(sq_low_ff);
         REG_SQ_MID:  prdata = CSR_DATA_W'(sq_mid_ff);
         REG_SQ_HIGH: prdata = CSR_DATA_W'(sq_high_ff);
         REG_MODE:    prdata = CSR_DATA_W'(mode_ff);
      endcase
   end

   // The three registers together hold the 25 cells back to back, cell 0 in
   // the lowest five bits, so the square is simply their concatenation.
   assign cells = {sq_high_ff, sq_mid_ff, sq_low_ff};

   pfc_match u_match (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cells      (cells),
      .down_valid (s1_valid),
      .down_ready (s1_ready),
      .down_data  (s1_data)
   );

   pfc_locate u_locate (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (s1_valid),
      .up_ready   (s1_ready),
      .up_data    (s1_data),
      .down_valid (s2_valid),
      .down_ready (s2_ready),
      .down_data  (s2_data)
   );

   pfc_route u_route (
      .clock      (clock),
      .reset      (reset),
      .decrypt    (mode_ff),
      .up_valid   (s2_valid),
      .up_ready   (s2_ready),
      .up_data    (s2_data),
      .down_valid (s3_valid),
      .down_ready (s3_ready),
      .down_data  (s3_data)
   );

   pfc_select u_select (
      .clock    (clock),
      .reset    (reset),
      .cells    (cells),
      .up_valid (s3_valid),
      .up_ready (s3_ready),
      .up_data  (s3_data),
      .rsp_chan (rsp_chan)
   );

   // A missing letter always yields an all-zero pair.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.not_found |->
         rsp_chan.out_first == '0 && rsp_chan.out_second == '0)
      else $error("not_found beat carries nonzero letters");

   // When the consumer takes beats, every stage can move, so the input is open.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("input stalled while output is ready");

   // A mode write lands in the mode register at the next edge.
   assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == REG_MODE |=> mode_ff == $past(pwdata[0]))
      else $error("decrypt mode write lost");

   // The low square register only changes through a write to its address.
   assert property (@(posedge clock) disable iff (reset)
      !(csr_write && csr_index == REG_SQ_LOW) |=> $stable(sq_low_ff))
      else $error("square register changed without a write");
endmodule

[verif/tb_playfair_digraph_cipher_top.sv]
// Self-checking testbench for the Playfair digraph cipher top level.
module tb_playfair_digraph_cipher_top;
   import pfc_pkg::*;

   // One predicted result beat: the transformed pair and the lookup flag.
   typedef struct packed {
      letter_type out_first;
      letter_type out_second;
      logic       not_found;
   } cipher_beat_type;

   // Shapes of key square that the phases load.
   typedef enum {
      SQ_ALPHABET, SQ_SHUFFLED, SQ_DUPLICATES, SQ_WILD, SQ_ALL_ONES, SQ_ZERO, SQ_HIGH_CODES
   } square_kind_type;

   // Flow-control patterns on the two channels.
   typedef enum { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_kind_type;

   // The scoreboard keeps its own copy of the registers, predicts the cipher pair for
   // every accepted request beat and matches result beats against those predictions
   // in order. Its register copy starts at the reset values.
   class cipher_scoreboard;
      logic [SQ_LOW_W-1:0]  cells_low  = '0;
      logic [SQ_MID_W-1:0]  cells_mid  = '0;
      logic [SQ_HIGH_W-1:0] cells_high = '0;
      logic                 decrypt    = 1'b0;
      cipher_beat_type      expected_pairs[$];
      int                   errors;

      function void set_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_SQ_LOW:  cells_low  = value[SQ_LOW_W-1:0];
            REG_SQ_MID:  cells_mid  = value[SQ_MID_W-1:0];
            REG_SQ_HIGH: cells_high = value[SQ_HIGH_W-1:0];
            REG_MODE:    decrypt    = value[0];
         endcase
      endfunction

      function letter_type cell_at(int n);
         if (n < 8) begin
            return cells_low[5*n +: 5];
         end else if (n < 16) begin
            return cells_mid[5*(n-8) +: 5];
         end
         return cells_high[5*(n-16) +: 5];
      endfunction

      // The first cell in row-major order that holds the letter wins.
      function bit find_cell(letter_type letter, output int row, output int col);
         row = 0;
         col = 0;
         for (int n = 0; n < CELLS; n++) begin
            if (cell_at(n) == letter) begin
               row = n / SIDE;
               col = n % SIDE;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function cipher_beat_type cipher_pair(letter_type first_letter,
                                            letter_type second_letter);
         int              r1, c1, r2, c2, step;
         bit              hit1, hit2;
         cipher_beat_type beat;
         beat = '0;
         step = decrypt ? SIDE - 1 : 1;
         hit1 = find_cell(first_letter, r1, c1);
         hit2 = find_cell(second_letter, r2, c2);
         if (!hit1 || !hit2) begin
            beat.not_found = 1'b1;
         end else if (r1 == r2) begin
            beat.out_first  = cell_at(r1 * SIDE + (c1 + step) % SIDE);
            beat.out_second = cell_at(r2 * SIDE + (c2 + step) % SIDE);
         end else if (c1 == c2) begin
            beat.out_first  = cell_at(((r1 + step) % SIDE) * SIDE + c1);
            beat.out_second = cell_at(((r2 + step) % SIDE) * SIDE + c2);
         end else begin
            beat.out_first  = cell_at(r1 * SIDE + c2);
            beat.out_second = cell_at(r2 * SIDE + c1);
         end
         return beat;
      endfunction

      function void note_pair(letter_type first_letter, letter_type second_letter);
         expected_pairs.insert(expected_pairs.size(), cipher_pair(first_letter, second_letter));
      endfunction

      function void check_result(letter_type got_first, letter_type got_second, logic got_nf);
         cipher_beat_type want;
         if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected result beat %0d %0d nf=%0d", $time, got_first,
                     got_second, got_nf);
            errors++;
            return;
         end
         want = expected_pairs.pop_front();
         if (got_first !== want.out_first) begin
            $display("%0t: out_first expected %0d, got %0d", $time, want.out_first, got_first);
            errors++;
         end
         if (got_second !== want.out_second) begin
            $display("%0t: out_second expected %0d, got %0d", $time, want.out_second,
                     got_second);
            errors++;
         end
         if (got_nf !== want.not_found) begin
            $display("%0t: not_found expected %0d, got %0d", $time, want.not_found, got_nf);
            errors++;
         end
      endfunction

      function int pending();
         return expected_pairs.size();
      endfunction
   endclass

   // Clock, reset and the configuration port.
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pfc_req_if req_chan ();
   pfc_rsp_if rsp_chan ();

   cipher_scoreboard board;

   // Percentages of cycles in which the sender holds back or the receiver stalls.
   int sender_idle_pct;
   int receiver_stall_pct;

   playfair_digraph_cipher_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver decides its ready for the coming edge at each falling edge. With a
   // zero stall rate it stays high, which lets the pipeline run at full rate.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Both channels are watched at the rising edge. Every accepted request beat is turned
   // into a prediction at once, and every accepted result beat is checked against the
   // oldest prediction still waiting.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            board.note_pair(req_chan.first_letter, req_chan.second_letter);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            board.check_result(rsp_chan.out_first, rsp_chan.out_second, rsp_chan.not_found);
         end
      end
   end

   // A register write is a setup phase followed by an access phase. Registers are 64 bits
   // apart since some of them are wider than 32 bits. The scoreboard copy is updated once
   // the access has completed, while the block holds no work.
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Builds a key square of the given shape, packs it five bits per cell into the three
   // square registers and writes those along with the mode.
   task automatic load_square(input square_kind_type kind, input logic decrypt);
      letter_type           cells[CELLS];
      letter_type           pool[26];
      letter_type           swap;
      int                   j;
      logic [SQ_LOW_W-1:0]  low;
      logic [SQ_MID_W-1:0]  mid;
      logic [SQ_HIGH_W-1:0] high;
      for (int i = 0; i < 26; i++) begin
         pool[i] = letter_type'(i);
      end
      for (int i = 25; i > 0; i--) begin
         j       = $urandom_range(i, 0);
         swap    = pool[i];
         pool[i] = pool[j];
         pool[j] = swap;
      end
      for (int n = 0; n < CELLS; n++) begin
         case (kind)
            // The classic square drops J so that the other 25 letters fit.
            SQ_ALPHABET:   cells[n] = letter_type'(n < 9 ? n : n + 1);
            SQ_SHUFFLED:   cells[n] = pool[n];
            SQ_DUPLICATES: cells[n] = letter_type'($urandom_range(7) * 3);
            SQ_WILD:       cells[n] = letter_type'($urandom_range(31));
            SQ_ALL_ONES:   cells[n] = '1;
            SQ_ZERO:       cells[n] = '0;
            // Codes from Z upward, each repeated, so that the first match rule is visible.
            SQ_HIGH_CODES: cells[n] = letter_type'(31 - (n % 7));
         endcase
      end
      low  = '0;
      mid  = '0;
      high = '0;
      for (int n = 0; n < 8; n++) begin
         low[5*n +: 5] = cells[n];
         mid[5*n +: 5] = cells[n+8];
      end
      for (int n = 0; n < 9; n++) begin
         high[5*n +: 5] = cells[n+16];
      end
      write_reg(REG_SQ_LOW, CSR_DATA_W'(low));
      write_reg(REG_SQ_MID, CSR_DATA_W'(mid));
      write_reg(REG_SQ_HIGH, CSR_DATA_W'(high));
      write_reg(REG_MODE, CSR_DATA_W'(decrypt));
   endtask

   task automatic set_idling(input idle_kind_type kind);
      case (kind)
         IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
         IDLE_BOTH:     begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
   endtask

   // Offers one pair and returns at the edge that accepts it. Valid stays high after the
   // beat so that back-to-back pairs need no bubble; an idle cycle lowers it at a falling
   // edge of its own.
   task automatic send_pair(input letter_type first_letter, input letter_type second_letter);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid         <= 1'b1;
      req_chan.first_letter  <= first_letter;
      req_chan.second_letter <= second_letter;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Ends a burst and waits until every predicted result has been seen, which leaves the
   // block idle for the next register writes.
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Most random pairs come from the loaded square, biased toward partners in the same
   // row or column and toward doubled letters, so that every rule is hit often. The rest
   // use arbitrary letters, which mostly miss in sparse or unusual squares.
   task automatic send_random_pair();
      int         n;
      int         pick;
      letter_type first_letter;
      letter_type second_letter;
      n            = $urandom_range(CELLS - 1);
      pick         = $urandom_range(99);
      first_letter = board.cell_at(n);
      if (pick < 25) begin
         second_letter = board.cell_at((n / SIDE) * SIDE + $urandom_range(SIDE - 1));
      end else if (pick < 45) begin
         second_letter = board.cell_at($urandom_range(SIDE - 1) * SIDE + n % SIDE);
      end else if (pick < 55) begin
         second_letter = first_letter;
      end else if (pick < 85) begin
         second_letter = board.cell_at($urandom_range(CELLS - 1));
      end else if (pick < 93) begin
         second_letter = letter_type'($urandom_range(25));
      end else begin
         first_letter  = letter_type'($urandom_range(25));
         second_letter = letter_type'($urandom_range(25));
      end
      send_pair(first_letter, second_letter);
   endtask

   initial begin : stimulus
      // Directed pairs on the classic square: same row with wrap, two rectangles, a doubled
      // letter, the missing J on either side, Z twice and an interior pair in one column.
      letter_type      dir_first[8]  = '{0, 0, 0, 3, 9, 0, 25, 7};
      letter_type      dir_second[8] = '{4, 20, 25, 3, 0, 9, 25, 13};
      square_kind_type phase_square[8] = '{SQ_SHUFFLED, SQ_SHUFFLED, SQ_DUPLICATES, SQ_WILD,
                                           SQ_ALL_ONES, SQ_ZERO, SQ_SHUFFLED, SQ_SHUFFLED};
      idle_kind_type   phase_idle[4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

      board                  = new;
      reset                  = 1'b1;
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      req_chan.valid         = 1'b0;
      req_chan.first_letter  = '0;
      req_chan.second_letter = '0;
      sender_idle_pct        = 0;
      receiver_stall_pct     = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Right after reset every cell holds A, so only A is found and A pairs stay A.
      send_pair(0, 0);
      send_pair(25, 25);
      send_pair(0, 25);
      drain();

      load_square(SQ_ALPHABET, 1'b0);
      foreach (dir_first[i]) send_pair(dir_first[i], dir_second[i]);
      drain();
      write_reg(REG_MODE, CSR_DATA_W'(1));
      foreach (dir_first[i]) send_pair(dir_first[i], dir_second[i]);
      drain();

      // Codes from Z upward with repeats: two codes in one row, a rectangle between two rows,
      // and a letter that does not appear at all.
      load_square(SQ_HIGH_CODES, 1'b0);
      send_pair(31, 30);
      send_pair(25, 31);
      send_pair(0, 31);
      drain();

      // Random phases. Each one loads a new square and mode, then runs under one of the
      // four flow-control patterns; each pattern meets a single mode (decrypt only where
      // the sender idles) and two squares, the all-zero and all-one register values among them.
      for (int p = 0; p < 8; p++) begin
         set_idling(phase_idle[p % 4]);
         load_square(phase_square[p], p[0]);
         repeat (240) send_random_pair();
         drain();
      end

      // The pipeline is four stages deep; a margin beyond that catches stray beats.
      repeat (16) @(posedge clock);
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest passing run, including stalled phases.
   initial begin
      #10000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
